// File: src/ejbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ejbp_pkg: shared types and constants of the equi-join build/probe block
// Field widths, item kind codes, the per-probe result limit and the
// control bundle that the sequencer broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package ejbp_pkg;

  localparam int KEY_W = 16;
  localparam int VAL_W = 16;
  localparam int CNT_W = 32;

  // at most this many pairs leave for one probe
  localparam int MAX_RESULTS = 64;
  localparam int FOUND_W     = $clog2(MAX_RESULTS + 1);

  // item kind codes
  localparam logic KIND_BUILD = 1'b0;
  localparam logic KIND_PROBE = 1'b1;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             start;      // seed the probe token at the head cell
    logic             advance;    // move the token one cell down the chain
    logic [KEY_W-1:0] wr_key;     // build tuple key
    logic [VAL_W-1:0] wr_value;   // build tuple value
    logic [KEY_W-1:0] probe_key;  // key of the probe in flight
  } cell_ctl_t;

endpackage

// File: src/equi_join_build_probe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// equi_join_build_probe: nested-loop equi-join over a chain of table cells
// Build requests (kind 0) store a (key, value) tuple in the next free cell;
// once all TABLE_DEPTH cells are filled, further builds are dropped. Probe
// requests (kind 1) send a token down the filled cells, one cell per cycle
// while the walk is not paused, and emit one pair per matching cell in slot
// order; the final pair of a probe carries out_last. A probe that matches
// nothing emits nothing. A probe holds the input through its token walk
// and the flush of its last pair, plus any output stall. Each pair waits
// one match in a holding register so the last one can be marked, then
// moves to the output register. At most MAX_RESULTS pairs leave per probe.
// out_pair_total counts pairs so far and saturates. Reset (rst_n low,
// synchronous) empties the table and clears the pair count and out_valid.
// While out_stall is high the output holds and the token walk pauses once
// a further match has nowhere to go; in_stall is high for the whole of a
// probe.
// ----------------------------------------------------------------------------
module equi_join_build_probe #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_kind,
  input  logic [ejbp_pkg::KEY_W-1:0]  in_key,
  input  logic [ejbp_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ejbp_pkg::KEY_W-1:0]  out_match_key,
  output logic [ejbp_pkg::VAL_W-1:0]  out_probe_value,
  output logic [ejbp_pkg::VAL_W-1:0]  out_build_value,
  output logic                        out_last,
  output logic [ejbp_pkg::CNT_W-1:0]  out_pair_total
);

  localparam int FILL_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]                     state_r, state_nxt;
  logic [FILL_W-1:0]              fill_r, fill_nxt;
  logic [FILL_W-1:0]              walk_cnt_r, walk_cnt_nxt;
  logic [ejbp_pkg::FOUND_W-1:0]   found_r, found_nxt;
  logic [ejbp_pkg::KEY_W-1:0]     pkey_r, pkey_nxt;
  logic [ejbp_pkg::VAL_W-1:0]     pval_r, pval_nxt;
  logic                           held_v_r, held_v_nxt;
  logic [ejbp_pkg::VAL_W-1:0]     held_val_r, held_val_nxt;
  logic [ejbp_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [ejbp_pkg::KEY_W-1:0]     out_key_r;
  logic [ejbp_pkg::VAL_W-1:0]     out_pval_r;
  logic [ejbp_pkg::VAL_W-1:0]     out_bval_r;
  logic                           out_last_r;
  logic [ejbp_pkg::CNT_W-1:0]     out_total_r;

  logic                           in_acc;
  logic                           build_acc;
  logic                           probe_acc;
  logic                           out_free;
  logic                           walk_done;
  logic                           any_hit;
  logic                           out_load;
  logic                           load_last;
  logic                           start;
  logic                           advance;
  logic [ejbp_pkg::VAL_W-1:0]     hit_val;
  ejbp_pkg::cell_ctl_t            ctl;

  logic [TABLE_DEPTH-1:0]         wr_sel;
  logic [TABLE_DEPTH-1:0]         hit;
  logic [TABLE_DEPTH-1:0]         tok;
  logic [TABLE_DEPTH-1:0]         tok_in;
  logic [ejbp_pkg::VAL_W-1:0]     cell_val [TABLE_DEPTH];

  // handshake qualifiers
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign build_acc = in_acc & (in_kind == ejbp_pkg::KIND_BUILD);
  assign probe_acc = in_acc & (in_kind == ejbp_pkg::KIND_PROBE);
  assign out_free  = ~out_valid_r | ~out_stall;

  // broadcast bundle
  assign ctl.start     = start;
  assign ctl.advance   = advance;
  assign ctl.wr_key    = in_key;
  assign ctl.wr_value  = in_value;
  assign ctl.probe_key = pkey_r;

  // cell chain
  assign tok_in[0] = 1'b0;
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign tok_in[i] = tok[i-1];
    end
    assign wr_sel[i] = build_acc & (fill_r == FILL_W'(i));

    ejbp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_en   (wr_sel[i]),
      .seed    ((i == 0) ? 1'b1 : 1'b0),
      .tok_in  (tok_in[i]),
      .tok_out (tok[i]),
      .hit     (hit[i]),
      .value   (cell_val[i])
    );
  end

  // pick the value of the cell that holds the token and matches
  always_comb begin
    hit_val = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_val = hit_val | (hit[i] ? cell_val[i] : '0);
    end
  end

  assign any_hit   = |hit;
  assign walk_done = (walk_cnt_r == fill_r) ||
                     (found_r == ejbp_pkg::FOUND_W'(ejbp_pkg::MAX_RESULTS));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    walk_cnt_nxt = walk_cnt_r;
    found_nxt    = found_r;
    pkey_nxt     = pkey_r;
    pval_nxt     = pval_r;
    held_v_nxt   = held_v_r;
    held_val_nxt = held_val_r;
    start        = 1'b0;
    advance      = 1'b0;
    out_load     = 1'b0;
    load_last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (probe_acc) begin
          state_nxt    = ST_WALK;
          pkey_nxt     = in_key;
          pval_nxt     = in_value;
          walk_cnt_nxt = '0;
          found_nxt    = '0;
          held_v_nxt   = 1'b0;
          start        = 1'b1;
        end
        if (build_acc && (fill_r != FILL_W'(TABLE_DEPTH))) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_FLUSH;
        end else if (!any_hit || !held_v_r || out_free) begin
          advance      = 1'b1;
          walk_cnt_nxt = walk_cnt_r + FILL_W'(1);
          if (any_hit) begin
            found_nxt    = found_r + ejbp_pkg::FOUND_W'(1);
            held_v_nxt   = 1'b1;
            held_val_nxt = hit_val;
            out_load     = held_v_r;
          end
        end
      end
      ST_FLUSH: begin
        if (!held_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_load   = 1'b1;
          load_last  = 1'b1;
          held_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // saturating pair count and output valid
  always_comb begin
    cnt_nxt = cnt_r;
    if (out_load && (cnt_r != '1)) begin
      cnt_nxt = cnt_r + ejbp_pkg::CNT_W'(1);
    end
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      walk_cnt_r  <= '0;
      found_r     <= '0;
      held_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      found_r     <= found_nxt;
      held_v_r    <= held_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pkey_r     <= pkey_nxt;
    pval_r     <= pval_nxt;
    held_val_r <= held_val_nxt;
    if (out_load) begin
      out_key_r   <= pkey_r;
      out_pval_r  <= pval_r;
      out_bval_r  <= held_val_r;
      out_last_r  <= load_last;
      out_total_r <= cnt_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_key   = out_key_r;
  assign out_probe_value = out_pval_r;
  assign out_build_value = out_bval_r;
  assign out_last        = out_last_r;
  assign out_pair_total  = out_total_r;

endmodule

// File: src/ejbp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ejbp_cell: one table slot of the join chain
// Holds one stored tuple and one bit of the probe token. The token moves
// from neighbor to neighbor; the cell flags a hit while it holds the token
// and its stored key equals the probe key.
// ----------------------------------------------------------------------------
module ejbp_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ejbp_pkg::cell_ctl_t       ctl,
  input  logic                      wr_en,
  input  logic                      seed,
  input  logic                      tok_in,
  output logic                      tok_out,
  output logic                      hit,
  output logic [ejbp_pkg::VAL_W-1:0] value
);

  logic [ejbp_pkg::KEY_W-1:0] key_r;
  logic [ejbp_pkg::VAL_W-1:0] value_r;
  logic                       tok_r;
  logic                       tok_nxt;

  // store the build tuple
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r   <= ctl.wr_key;
      value_r <= ctl.wr_value;
    end
  end

  // seed or pass the token
  always_comb begin
    priority if (ctl.start) begin
      tok_nxt = seed;
    end else if (ctl.advance) begin
      tok_nxt = tok_in;
    end else begin
      tok_nxt = tok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;
  assign hit     = tok_r & (key_r == ctl.probe_key);
  assign value   = value_r;

endmodule

// File: src/ejbp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ejbp_checker: port-level checks for the equi-join block
// Watches the top level's ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module ejbp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_kind,
  input logic [ejbp_pkg::KEY_W-1:0]  in_key,
  input logic [ejbp_pkg::VAL_W-1:0]  in_value,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ejbp_pkg::KEY_W-1:0]  out_match_key,
  input logic [ejbp_pkg::VAL_W-1:0]  out_probe_value,
  input logic [ejbp_pkg::VAL_W-1:0]  out_build_value,
  input logic                        out_last,
  input logic [ejbp_pkg::CNT_W-1:0]  out_pair_total
);

  // hold a stalled request
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_kind) && $stable(in_key) &&
      $stable(in_value))
    else $error("stalled request changed");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_key) &&
      $stable(out_probe_value) && $stable(out_build_value) &&
      $stable(out_last) && $stable(out_pair_total))
    else $error("stalled result changed");

  // advance the pair count by one per taken pair until it saturates
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_pair_total != '1) |=>
      !out_valid || (out_pair_total == $past(out_pair_total) + 1'b1))
    else $error("pair count did not step by one");

  // never show a zero count on a result
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pair_total != '0)
    else $error("result with zero pair count");

  // a probe is still running while a pair that is not its last leaves
  a_busy_after_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |-> in_stall)
    else $error("input taken before probe finished");

endmodule

bind equi_join_build_probe ejbp_checker u_ejbp_checker (.*);

// File: verif/tb_equi_join_build_probe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_equi_join_build_probe: self-checking bench for the build/probe equi-join
// Drives build and probe requests through the valid/stall input channel and
// checks every emitted pair against an in-bench join table that mirrors the
// block's slots and saturating pair count. A directed burst hits the field
// extremes, the empty-table probe and multi-match probes. Random traffic then
// fills the table past capacity and probes it from a small key pool, under
// phases of sender idling, receiver stalling and both.
// ----------------------------------------------------------------------------
module tb_equi_join_build_probe;

  localparam int DEPTH        = 64;
  localparam int RAND_ITEMS   = 88;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int STALL_LIMIT  = 5000;
  localparam int PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [ejbp_pkg::KEY_W-1:0] match_key;
    logic [ejbp_pkg::VAL_W-1:0] probe_value;
    logic [ejbp_pkg::VAL_W-1:0] build_value;
    logic                       last;
    logic [ejbp_pkg::CNT_W-1:0] total;
  } join_pair_t;

  // Join table mirror and the queue of pairs still owed by the block
  class join_scoreboard;
    logic [ejbp_pkg::KEY_W-1:0] slot_key [DEPTH];
    logic [ejbp_pkg::VAL_W-1:0] slot_val [DEPTH];
    int unsigned                filled;
    logic [ejbp_pkg::CNT_W-1:0] pair_count;
    join_pair_t                 owed_pairs [$];

    function new();
      filled     = 0;
      pair_count = '0;
    endfunction

    // Queue one owed pair behind the others
    function void append_owed(join_pair_t p);
      owed_pairs = {owed_pairs, p};
    endfunction

    // Store a build tuple, or expand a probe into its pairs in slot order
    function void note_request(logic kind, logic [ejbp_pkg::KEY_W-1:0] key,
                               logic [ejbp_pkg::VAL_W-1:0] value);
      int         found;
      bit         have_held;
      join_pair_t held;
      found     = 0;
      have_held = 0;
      if (kind == ejbp_pkg::KIND_BUILD) begin
        if (filled < DEPTH) begin
          slot_key[filled] = key;
          slot_val[filled] = value;
          filled++;
        end
        return;
      end
      for (int s = 0; s < filled; s++) begin
        if (slot_key[s] != key) continue;
        if (found >= ejbp_pkg::MAX_RESULTS) break;
        if (pair_count != '1) pair_count++;
        // hold each pair until we know whether another follows
        if (have_held) append_owed(held);
        held.match_key   = key;
        held.probe_value = value;
        held.build_value = slot_val[s];
        held.last        = 1'b0;
        held.total       = pair_count;
        have_held        = 1;
        found++;
      end
      if (have_held) begin
        held.last = 1'b1;
        append_owed(held);
      end
    endfunction

    function int pending();
      return owed_pairs.size();
    endfunction

    // Compare one emitted pair with the oldest owed pair; empty string if clean
    function string check_pair(join_pair_t got);
      join_pair_t want;
      string      msg;
      msg = "";
      if (owed_pairs.size() == 0)
        return $sformatf("unexpected pair key=%h probe=%h build=%h last=%b total=%0d",
                         got.match_key, got.probe_value, got.build_value,
                         got.last, got.total);
      want = owed_pairs.pop_front();
      if (got.match_key !== want.match_key)
        msg = {msg, $sformatf(" match_key %h/%h", got.match_key, want.match_key)};
      if (got.probe_value !== want.probe_value)
        msg = {msg, $sformatf(" probe_value %h/%h", got.probe_value, want.probe_value)};
      if (got.build_value !== want.build_value)
        msg = {msg, $sformatf(" build_value %h/%h", got.build_value, want.build_value)};
      if (got.last !== want.last)
        msg = {msg, $sformatf(" last %b/%b", got.last, want.last)};
      if (got.total !== want.total)
        msg = {msg, $sformatf(" pair_total %0d/%0d", got.total, want.total)};
      if (msg != "") msg = {"pair mismatch (got/exp):", msg};
      return msg;
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_kind;
  logic [ejbp_pkg::KEY_W-1:0] in_key;
  logic [ejbp_pkg::VAL_W-1:0] in_value;
  logic                       out_valid;
  logic                       out_stall;
  logic [ejbp_pkg::KEY_W-1:0] out_match_key;
  logic [ejbp_pkg::VAL_W-1:0] out_probe_value;
  logic [ejbp_pkg::VAL_W-1:0] out_build_value;
  logic                       out_last;
  logic [ejbp_pkg::CNT_W-1:0] out_pair_total;

  join_scoreboard join_sb;
  int             error_count    = 0;
  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  int             quiet_cycles   = 0;

  equi_join_build_probe #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_match_key  (out_match_key),
    .out_probe_value(out_probe_value),
    .out_build_value(out_build_value),
    .out_last       (out_last),
    .out_pair_total (out_pair_total)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (error_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Issue one request, idling first at the current rate; return once accepted
  task automatic send_request(logic kind, logic [ejbp_pkg::KEY_W-1:0] key,
                              logic [ejbp_pkg::VAL_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    join_sb.note_request(kind, key, value);
  endtask

  // Draw a key, weighted toward a few hot keys so probes find several matches
  function automatic logic [ejbp_pkg::KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return 16'h0000;
    if (roll < 50) return 16'hFFFF;
    if (roll < 65) return 16'h8001;
    if (roll < 75) return 16'h7FFE;
    return ejbp_pkg::KEY_W'($urandom);
  endfunction

  // Accept pairs and check them; randomize stall for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      string msg;
      msg = join_sb.check_pair('{out_match_key, out_probe_value, out_build_value,
                                 out_last, out_pair_total});
      if (msg != "") report_mismatch(msg);
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Abort when no request or pair has moved for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int  counted;
    bit  is_build;
    join_sb   = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_kind   = ejbp_pkg::KIND_BUILD;
    in_key    = '0;
    in_value  = '0;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table probe, extremes, duplicate keys, no-match probe
    send_request(ejbp_pkg::KIND_PROBE, 16'h0000, 16'hFFFF);
    send_request(ejbp_pkg::KIND_BUILD, 16'h0000, 16'hFFFF);
    send_request(ejbp_pkg::KIND_BUILD, 16'hFFFF, 16'h0000);
    send_request(ejbp_pkg::KIND_BUILD, 16'h0000, 16'h1234);
    send_request(ejbp_pkg::KIND_BUILD, 16'hA5A5, 16'h5A5A);
    send_request(ejbp_pkg::KIND_PROBE, 16'h0000, 16'h0000);
    send_request(ejbp_pkg::KIND_PROBE, 16'hFFFF, 16'hFFFF);
    send_request(ejbp_pkg::KIND_PROBE, 16'h1111, 16'hABCD);
    send_request(ejbp_pkg::KIND_PROBE, 16'hA5A5, 16'h8001);
    send_request(ejbp_pkg::KIND_BUILD, 16'h5A5A, 16'hA5A5);
    send_request(ejbp_pkg::KIND_PROBE, 16'h5A5A, 16'h7FFE);
    send_request(ejbp_pkg::KIND_PROBE, 16'hFFFE, 16'h0001);

    // Random: fill past capacity, then mostly probe; step through idle phases
    counted = 0;
    while (counted < RAND_ITEMS) begin
      case (counted * 4 / RAND_ITEMS)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      if (join_sb.filled < DEPTH) is_build = ($urandom_range(99) < 80);
      else                        is_build = ($urandom_range(99) < 25);
      counted++;
      send_request(is_build ? ejbp_pkg::KIND_BUILD : ejbp_pkg::KIND_PROBE, pick_key(),
                   ejbp_pkg::VAL_W'($urandom));
    end
    in_valid <= 1'b0;

    // Drain owed pairs, then watch for strays
    while (join_sb.pending() > 0) @(posedge clk);
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
src/ejbp_pkg.sv
src/ejbp_cell.sv
src/equi_join_build_probe.sv
src/ejbp_checker.sv
verif/tb_equi_join_build_probe.sv
